// ----- design/swam_pkg.sv -----
// shared types and constants for the sliding window anagram matcher
// no dependencies; used by sliding_window_anagram_match
package swam_pkg;

  localparam int MAX_WINDOW_DEF = 1024;
  localparam int ALPHABET_DEF   = 26;
  localparam int LETTER_W       = 5;
  localparam int REQ_W          = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [LETTER_W-1:0] letter;
  } in_t;

  typedef struct packed {
    logic match;
    logic window_full;
    logic found_any;
    logic pattern_overflow;
  } out_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic                clear;
    logic                restart;
    logic                pat_inc;
    logic                win_inc;
    logic                evict;
    logic                text;
    logic                full;
    logic                ovf;
    logic [LETTER_W-1:0] letter;
  } stage_t;

endpackage

// ----- design/swam_ram.sv -----
// generic single-write, single-read ram with registered, read-first output
// no dependencies
module swam_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sliding_window_anagram_match.sv -----
// sliding window anagram matcher: pattern histogram, window histogram, letter ring
// depends on swam_pkg and swam_ram
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------------
//   in      | in_valid, in_ready, in_data   | req_type, letter
//   out     | out_valid, out_ready, out_data| match, window_full, found_any, ovf
//
// one item per cycle unless the output stalls; after the input transfer the result is registered
// in order through ring read, histogram update, histogram compare into the output register
// up to three items are in flight, so input keeps flowing while a result waits
// synchronous active-low reset clears counters and histograms at once, no sweep
// a stall at the output backs up stage by stage; in_ready drops only when all are full
module sliding_window_anagram_match #(
  parameter int MAX_WINDOW = swam_pkg::MAX_WINDOW_DEF,
  parameter int ALPHABET   = swam_pkg::ALPHABET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swam_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output swam_pkg::out_t out_data
);

  import swam_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // front control state
  logic [CNT_W-1:0] plen_r, plen_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;

  // pipeline
  logic   b_valid_r, c_valid_r, out_valid_r;
  stage_t a_st, b_r, c_r;
  out_t   out_data_r, out_nxt;
  logic   found_r, found_nxt;

  logic [CNT_W-1:0] phist_r [ALPHABET];
  logic [CNT_W-1:0] whist_r [ALPHABET];
  logic [CNT_W-1:0] phist_nxt [ALPHABET];
  logic [CNT_W-1:0] whist_nxt [ALPHABET];

  logic accept, out_ld, c_free, b_free, b_mv, c_mv;
  logic ring_we, ring_re;
  logic [PTR_W-1:0] ring_raddr;
  logic [LETTER_W-1:0] ring_rdata;
  logic [CNT_W-1:0] ptr_ext, old_ext;
  logic letter_ok, hist_eq;

  assign out_ld   = !out_valid_r || out_ready;
  assign c_free   = !c_valid_r || out_ld;
  assign c_mv     = c_valid_r && out_ld;
  assign b_free   = !b_valid_r || c_free;
  assign b_mv     = b_valid_r && c_free;
  assign in_ready = b_free;
  assign accept   = in_valid && in_ready;

  assign letter_ok = int'(in_data.letter) < ALPHABET;
  assign ptr_ext   = CNT_W'(ptr_r);
  assign old_ext   = (ptr_ext >= plen_r) ? ptr_ext - plen_r
                                         : ptr_ext + CNT_W'(MAX_WINDOW) - plen_r;
  assign ring_raddr = old_ext[PTR_W-1:0];

  // front stage: counters, ring access and per-item control
  always_comb begin
    plen_nxt = plen_r;
    seen_nxt = seen_r;
    ptr_nxt  = ptr_r;
    a_st     = '0;
    a_st.letter = in_data.letter;
    ring_we  = 1'b0;
    ring_re  = 1'b0;
    case (in_data.req_type)
      REQ_PATTERN: begin
        if (letter_ok) begin
          if (seen_r != '0) begin
            a_st.restart = 1'b1;
            seen_nxt     = '0;
            ptr_nxt      = '0;
          end
          if (plen_r >= CNT_W'(MAX_WINDOW)) begin
            a_st.ovf = 1'b1;
          end else begin
            a_st.pat_inc = 1'b1;
            plen_nxt     = plen_r + 1'b1;
          end
        end
      end
      REQ_TEXT: begin
        if (letter_ok) begin
          a_st.text = 1'b1;
          if (plen_r != '0) begin
            a_st.win_inc = 1'b1;
            ring_we      = 1'b1;
            if (seen_r >= plen_r) begin
              a_st.evict = 1'b1;
              ring_re    = 1'b1;
            end else begin
              seen_nxt = seen_r + 1'b1;
            end
            if (ptr_ext + 1'b1 >= CNT_W'(MAX_WINDOW)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end
          a_st.full = seen_nxt >= plen_r;
        end
      end
      REQ_CLEAR: begin
        a_st.clear = 1'b1;
        plen_nxt   = '0;
        seen_nxt   = '0;
        ptr_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  swam_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ring_we),
    .waddr (ptr_r),
    .wdata (in_data.letter),
    .re    (accept && ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // histogram update: add new pattern and text letters, remove the departing letter from the ring
  always_comb begin
    for (int k = 0; k < ALPHABET; k++) begin
      phist_nxt[k] = b_r.clear ? '0 : phist_r[k];
      if (b_r.pat_inc && int'(b_r.letter) == k) begin
        phist_nxt[k] = phist_nxt[k] + 1'b1;
      end
      whist_nxt[k] = (b_r.clear || b_r.restart) ? '0 : whist_r[k];
      if (b_r.evict && int'(ring_rdata) == k && whist_nxt[k] != '0) begin
        whist_nxt[k] = whist_nxt[k] - 1'b1;
      end
      if (b_r.win_inc && int'(b_r.letter) == k) begin
        whist_nxt[k] = whist_nxt[k] + 1'b1;
      end
    end
  end

  // compare stage
  always_comb begin
    hist_eq = 1'b1;
    for (int k = 0; k < ALPHABET; k++) begin
      if (phist_r[k] != whist_r[k]) begin
        hist_eq = 1'b0;
      end
    end
    out_nxt.match            = c_r.text && c_r.full && hist_eq;
    out_nxt.window_full      = c_r.text && c_r.full;
    found_nxt                = ((c_r.clear || c_r.restart) ? 1'b0 : found_r) || out_nxt.match;
    out_nxt.found_any        = found_nxt;
    out_nxt.pattern_overflow = c_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      seen_r      <= '0;
      ptr_r       <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      for (int k = 0; k < ALPHABET; k++) begin
        phist_r[k] <= '0;
        whist_r[k] <= '0;
      end
    end else begin
      if (accept) begin
        plen_r <= plen_nxt;
        seen_r <= seen_nxt;
        ptr_r  <= ptr_nxt;
      end
      if (b_free) begin
        b_valid_r <= accept;
      end
      if (c_free) begin
        c_valid_r <= b_mv;
      end
      if (out_ld) begin
        out_valid_r <= c_mv;
      end
      if (b_mv) begin
        for (int k = 0; k < ALPHABET; k++) begin
          phist_r[k] <= phist_nxt[k];
          whist_r[k] <= whist_nxt[k];
        end
      end
      if (c_mv) begin
        found_r <= found_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      b_r <= a_st;
    end
    if (b_mv) begin
      c_r <= b_r;
    end
    if (c_mv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // window count saturates at the pattern length
  a_seen_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= plen_r)
    else $error("text count above pattern length");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < MAX_WINDOW)
    else $error("ring pointer out of range");

  a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r == '0 |-> seen_r == '0 && ptr_r == '0)
    else $error("window state without a pattern");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.req_type == REQ_CLEAR |=> plen_r == '0 && seen_r == '0)
    else $error("clear transfer did not reset counters");

  a_match_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.match |-> out_data_r.window_full && out_data_r.found_any)
    else $error("match without full window or found flag");
`endif

endmodule
